// File: design/lkv_pkg.sv
`default_nettype none
package lkv_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int RANK_W      = IDX_W;
  localparam int LIMIT_W     = 5;
  localparam int WORD_W      = 64;
  localparam int KEY_W       = 2 * WORD_W;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 2'd2;

  typedef struct packed {
    logic             key_we;
    logic             val_we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic             touch;
    logic             insert;
    logic             evict;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] victim;
  } rank_op_t;

endpackage
`default_nettype wire

// File: design/lkv_store.sv
`default_nettype none
module lkv_store (
  input  wire                       clk_i,
  input  lkv_pkg::store_req_t       req_i,
  input  wire [lkv_pkg::KEY_W-1:0]  wkey_i,
  input  wire [lkv_pkg::KEY_W-1:0]  wval_i,
  output logic [lkv_pkg::KEY_W-1:0] rkey_o,
  output logic [lkv_pkg::KEY_W-1:0] rval_o
);

  logic [lkv_pkg::KEY_W-1:0] key_mem [lkv_pkg::TABLE_DEPTH];
  logic [lkv_pkg::KEY_W-1:0] val_mem [lkv_pkg::TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.key_we) begin
      key_mem[req_i.waddr] <= wkey_i;
    end
    if (req_i.val_we) begin
      val_mem[req_i.waddr] <= wval_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_o <= key_mem[req_i.raddr];
    rval_o <= val_mem[req_i.raddr];
  end

endmodule
`default_nettype wire

// File: design/lkv_rank.sv
`default_nettype none
module lkv_rank (
  input  wire                                               clk_i,
  input  wire                                               rst_ni,
  input  lkv_pkg::rank_op_t                                 op_i,
  output logic [lkv_pkg::TABLE_DEPTH-1:0]                   valid_o,
  output logic [lkv_pkg::TABLE_DEPTH-1:0][lkv_pkg::RANK_W-1:0] rank_o,
  output logic [lkv_pkg::CNT_W-1:0]                         count_o
);

  logic [lkv_pkg::TABLE_DEPTH-1:0]                      valid_q, valid_d;
  logic [lkv_pkg::TABLE_DEPTH-1:0][lkv_pkg::RANK_W-1:0] rank_q, rank_d;
  logic [lkv_pkg::CNT_W-1:0]                            count_q, count_d;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    count_d = count_q;
    if (op_i.touch) begin
      for (int i = 0; i < lkv_pkg::TABLE_DEPTH; i++) begin
        if (valid_q[i] && (rank_q[i] < rank_q[op_i.slot])) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
      rank_d[op_i.slot] = '0;
    end else if (op_i.insert) begin
      for (int i = 0; i < lkv_pkg::TABLE_DEPTH; i++) begin
        if (valid_q[i] && !(op_i.evict && (lkv_pkg::IDX_W'(i) == op_i.victim))) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
      if (op_i.evict) begin
        valid_d[op_i.victim] = 1'b0;
      end else begin
        count_d = count_q + 1'b1;
      end
      valid_d[op_i.slot] = 1'b1;
      rank_d[op_i.slot]  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      count_q <= count_d;
    end
  end

  assign valid_o = valid_q;
  assign rank_o  = rank_q;
  assign count_o = count_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == count_q)
    else $error("entry count out of step with valid bits");

  a_touch_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i.touch |-> valid_q[op_i.slot] && !op_i.insert)
    else $error("recency touch on an empty slot");

  a_evict_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i.insert && op_i.evict) |-> valid_q[op_i.victim])
    else $error("eviction of an empty slot");

endmodule
`default_nettype wire

// File: design/lru_key_value_table_top.sv
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    command_i, key_*_i, value_*_i
// out      out_valid_o / out_ready_i  status_o, found_value_*_o, evicted*_o
// cfg      psel/penable/pwrite/pready paddr, pwdata, prdata (entry_limit)
//
// A lookup hit or a new add passes through the scan, decide and fetch states
// before its result is valid; a miss, an update or a duplicate add skips the fetch
// state, and a no-operation command goes straight to the result. The scan uses
// the single 128-bit key comparator walking the key memory one slot a cycle.
// The next item is taken once the result has been transferred out.
// Reset clears the table at once; no clearing pass is needed.
`default_nettype none
module lru_key_value_table_top (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  [lkv_pkg::CMD_W-1:0]           command_i,
  input  wire  [lkv_pkg::WORD_W-1:0]          key_high_i,
  input  wire  [lkv_pkg::WORD_W-1:0]          key_low_i,
  input  wire  [lkv_pkg::WORD_W-1:0]          value_high_i,
  input  wire  [lkv_pkg::WORD_W-1:0]          value_low_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [lkv_pkg::STATUS_W-1:0]        status_o,
  output logic [lkv_pkg::WORD_W-1:0]          found_value_high_o,
  output logic [lkv_pkg::WORD_W-1:0]          found_value_low_o,
  output logic                                evicted_o,
  output logic [lkv_pkg::WORD_W-1:0]          evicted_key_high_o,
  output logic [lkv_pkg::WORD_W-1:0]          evicted_key_low_o,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [lkv_pkg::PADDR_W-1:0]         paddr,
  input  wire  [lkv_pkg::PDATA_W-1:0]         pwdata,
  output logic [lkv_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int IDX_W = lkv_pkg::IDX_W;
  localparam int CNT_W = lkv_pkg::CNT_W;
  localparam int CMP_W = (lkv_pkg::CNT_W > lkv_pkg::LIMIT_W) ? lkv_pkg::CNT_W
                                                              : lkv_pkg::LIMIT_W;
  localparam int W     = lkv_pkg::WORD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FETCH,
    S_RESP
  } state_e;

  state_e                         state_q, state_d;
  logic [lkv_pkg::CMD_W-1:0]      cmd_q, cmd_d;
  logic [lkv_pkg::KEY_W-1:0]      key_q, key_d;
  logic [lkv_pkg::KEY_W-1:0]      val_q, val_d;
  logic [CNT_W-1:0]               scan_q, scan_d;
  logic                           cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]               cmp_idx_q, cmp_idx_d;
  logic                           hit_q, hit_d;
  logic [IDX_W-1:0]               found_q, found_d;
  logic                           lru_vld_q, lru_vld_d;
  logic [IDX_W-1:0]               lru_q, lru_d;
  logic [lkv_pkg::RANK_W-1:0]     lru_rank_q, lru_rank_d;
  logic                           free_vld_q, free_vld_d;
  logic [IDX_W-1:0]               free_q, free_d;
  logic                           evict_q, evict_d;
  logic                           out_valid_q, out_valid_d;
  logic [lkv_pkg::STATUS_W-1:0]   status_q, status_d;
  logic [lkv_pkg::KEY_W-1:0]      found_val_q, found_val_d;
  logic                           evicted_q, evicted_d;
  logic [lkv_pkg::KEY_W-1:0]      ev_key_q, ev_key_d;
  logic [lkv_pkg::LIMIT_W-1:0]    limit_q;

  lkv_pkg::store_req_t            store_req;
  lkv_pkg::rank_op_t              rank_op;
  logic [lkv_pkg::KEY_W-1:0]      rd_key, rd_val;
  logic [lkv_pkg::TABLE_DEPTH-1:0] valid;
  logic [lkv_pkg::TABLE_DEPTH-1:0][lkv_pkg::RANK_W-1:0] rank;
  logic [CNT_W-1:0]               count;

  logic [CMP_W-1:0]               lim_x, cnt_x, lim_eff;
  logic                           evict_need, cmp_slot_valid, key_match;
  logic                           cfg_we;
  logic [IDX_W-1:0]               ins_slot;

  lkv_store u_store (
    .clk_i  (clk_i),
    .req_i  (store_req),
    .wkey_i (key_q),
    .wval_i (val_q),
    .rkey_o (rd_key),
    .rval_o (rd_val)
  );

  lkv_rank u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (rank_op),
    .valid_o (valid),
    .rank_o  (rank),
    .count_o (count)
  );

  assign cfg_we = psel && penable && pwrite && pready && !paddr[lkv_pkg::PADDR_W-1];
  assign pready = 1'b1;
  assign prdata = paddr[lkv_pkg::PADDR_W-1] ? '0 : lkv_pkg::PDATA_W'(limit_q);

  always_comb begin
    lim_x = CMP_W'(limit_q);
    cnt_x = CMP_W'(count);
    if (lim_x == '0) begin
      lim_eff = CMP_W'(1);
    end else if (lim_x > CMP_W'(lkv_pkg::TABLE_DEPTH)) begin
      lim_eff = CMP_W'(lkv_pkg::TABLE_DEPTH);
    end else begin
      lim_eff = lim_x;
    end
    evict_need = (cnt_x >= lim_eff) && (cnt_x != '0);
  end

  assign cmp_slot_valid = valid[cmp_idx_q];
  assign key_match      = cmp_slot_valid && (rd_key == key_q);
  assign ins_slot       = (free_vld_q && (!evict_q || (free_q < lru_q))) ? free_q : lru_q;
  assign in_ready_o     = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    scan_d      = scan_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    found_d     = found_q;
    lru_vld_d   = lru_vld_q;
    lru_d       = lru_q;
    lru_rank_d  = lru_rank_q;
    free_vld_d  = free_vld_q;
    free_d      = free_q;
    evict_d     = evict_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    found_val_d = found_val_q;
    evicted_d   = evicted_q;
    ev_key_d    = ev_key_q;

    store_req        = '0;
    store_req.raddr  = scan_q[IDX_W-1:0];
    store_req.waddr  = found_q;
    rank_op          = '0;
    rank_op.slot     = found_q;
    rank_op.victim   = lru_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = command_i;
          key_d       = {key_high_i, key_low_i};
          val_d       = {value_high_i, value_low_i};
          scan_d      = '0;
          cmp_vld_d   = 1'b0;
          hit_d       = 1'b0;
          lru_vld_d   = 1'b0;
          free_vld_d  = 1'b0;
          evict_d     = 1'b0;
          status_d    = lkv_pkg::ST_OK;
          found_val_d = '0;
          evicted_d   = 1'b0;
          ev_key_d    = '0;
          if (command_i == lkv_pkg::CMD_NOP) begin
            out_valid_d = 1'b1;
            state_d     = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmp_vld_d = (scan_q != CNT_W'(lkv_pkg::TABLE_DEPTH));
        cmp_idx_d = scan_q[IDX_W-1:0];
        if (cmp_vld_q) begin
          if (key_match && !hit_q) begin
            hit_d   = 1'b1;
            found_d = cmp_idx_q;
          end
          if (cmp_slot_valid && (!lru_vld_q || (rank[cmp_idx_q] > lru_rank_q))) begin
            lru_vld_d  = 1'b1;
            lru_d      = cmp_idx_q;
            lru_rank_d = rank[cmp_idx_q];
          end
          if (!cmp_slot_valid && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_d     = cmp_idx_q;
          end
        end
        if (scan_q == CNT_W'(lkv_pkg::TABLE_DEPTH)) begin
          state_d = S_DECIDE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_DECIDE: begin
        store_req.raddr = hit_q ? found_q : lru_q;
        case (cmd_q)
          lkv_pkg::CMD_LOOKUP: begin
            if (hit_q) begin
              state_d = S_FETCH;
            end else begin
              status_d    = lkv_pkg::ST_NOT_FOUND;
              out_valid_d = 1'b1;
              state_d     = S_RESP;
            end
          end
          lkv_pkg::CMD_UPDATE: begin
            if (hit_q) begin
              store_req.val_we = 1'b1;
            end else begin
              status_d = lkv_pkg::ST_NOT_FOUND;
            end
            out_valid_d = 1'b1;
            state_d     = S_RESP;
          end
          lkv_pkg::CMD_ADD: begin
            if (hit_q) begin
              status_d    = lkv_pkg::ST_EXISTS;
              out_valid_d = 1'b1;
              state_d     = S_RESP;
            end else begin
              evict_d = evict_need;
              state_d = S_FETCH;
            end
          end
          default: begin
            out_valid_d = 1'b1;
            state_d     = S_RESP;
          end
        endcase
      end
      S_FETCH: begin
        if (cmd_q == lkv_pkg::CMD_LOOKUP) begin
          found_val_d   = rd_val;
          rank_op.touch = 1'b1;
        end else begin
          evicted_d = evict_q;
          if (evict_q) begin
            ev_key_d = rd_key;
          end
          store_req.key_we = 1'b1;
          store_req.val_we = 1'b1;
          store_req.waddr  = ins_slot;
          rank_op.insert   = 1'b1;
          rank_op.evict    = evict_q;
          rank_op.slot     = ins_slot;
        end
        out_valid_d = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      limit_q     <= lkv_pkg::LIMIT_RESET;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      lru_vld_q   <= 1'b0;
      free_vld_q  <= 1'b0;
      evict_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      lru_vld_q   <= lru_vld_d;
      free_vld_q  <= free_vld_d;
      evict_q     <= evict_d;
      if (cfg_we) begin
        limit_q <= pwdata[lkv_pkg::LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    val_q       <= val_d;
    cmp_idx_q   <= cmp_idx_d;
    found_q     <= found_d;
    lru_q       <= lru_d;
    lru_rank_q  <= lru_rank_d;
    free_q      <= free_d;
    status_q    <= status_d;
    found_val_q <= found_val_d;
    evicted_q   <= evicted_d;
    ev_key_q    <= ev_key_d;
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign found_value_high_o = found_val_q[2*W-1:W];
  assign found_value_low_o  = found_val_q[W-1:0];
  assign evicted_o          = evicted_q;
  assign evicted_key_high_o = ev_key_q[2*W-1:W];
  assign evicted_key_low_o  = ev_key_q[W-1:0];

  a_fetch_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH && cmd_q == lkv_pkg::CMD_LOOKUP) |-> hit_q && valid[found_q])
    else $error("lookup fetch without a matching slot");

  a_room_for_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH && cmd_q == lkv_pkg::CMD_ADD) |-> (free_vld_q || evict_q))
    else $error("add with neither a free slot nor a victim");

  a_result_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> out_valid_o && !in_ready_o)
    else $error("fetch did not present a result");

endmodule
`default_nettype wire

// File: bench/lru_key_value_table_top_tb.sv
module lru_key_value_table_top_tb;
  import lkv_pkg::*;

  localparam logic [PADDR_W-1:0] REG_ENTRY_LIMIT = '0;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   found_hi;
    logic [WORD_W-1:0]   found_lo;
    logic                evicted;
    logic [WORD_W-1:0]   victim_hi;
    logic [WORD_W-1:0]   victim_lo;
  } table_reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i;
  logic [WORD_W-1:0]   key_high_i;
  logic [WORD_W-1:0]   key_low_i;
  logic [WORD_W-1:0]   value_high_i;
  logic [WORD_W-1:0]   value_low_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [WORD_W-1:0]   found_value_high_o;
  logic [WORD_W-1:0]   found_value_low_o;
  logic                evicted_o;
  logic [WORD_W-1:0]   evicted_key_high_o;
  logic [WORD_W-1:0]   evicted_key_low_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  lru_key_value_table_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .key_high_i         (key_high_i),
    .key_low_i          (key_low_i),
    .value_high_i       (value_high_i),
    .value_low_i        (value_low_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .found_value_high_o (found_value_high_o),
    .found_value_low_o  (found_value_low_o),
    .evicted_o          (evicted_o),
    .evicted_key_high_o (evicted_key_high_o),
    .evicted_key_low_o  (evicted_key_low_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the table
  logic [WORD_W-1:0]  row_key_hi [TABLE_DEPTH];
  logic [WORD_W-1:0]  row_key_lo [TABLE_DEPTH];
  logic [WORD_W-1:0]  row_val_hi [TABLE_DEPTH];
  logic [WORD_W-1:0]  row_val_lo [TABLE_DEPTH];
  bit                 row_live   [TABLE_DEPTH];
  int unsigned        row_age    [TABLE_DEPTH];
  int unsigned        live_rows;
  logic [LIMIT_W-1:0] limit_reg;

  table_reply_t awaited_replies[$];
  table_reply_t head_reply;

  logic [WORD_W-1:0] pool_hi [32];
  logic [WORD_W-1:0] pool_lo [32];
  int pool_n;

  bit tx_idle_en;
  bit rx_idle_en;
  int rx_hold_left;
  int fail_count;
  int items_sent;
  int replies_checked;
  int hit_count;
  int evict_count;
  int miss_count;
  int dup_count;
  int limit_writes;

  function automatic int unsigned capacity();
    if (limit_reg == 0) return 1;
    if (limit_reg > TABLE_DEPTH) return TABLE_DEPTH;
    return limit_reg;
  endfunction

  function automatic void table_apply(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] kh,
                                      logic [WORD_W-1:0] kl, logic [WORD_W-1:0] vh,
                                      logic [WORD_W-1:0] vl);
    table_reply_t r;
    int hit;
    int victim;
    int free_row;
    r = '0;
    hit = -1;
    victim = -1;
    free_row = -1;
    if (cmd == CMD_NOP) begin
      awaited_replies.push_back(r);
      return;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit < 0 && row_live[i] && row_key_hi[i] == kh && row_key_lo[i] == kl) hit = i;
    end
    if (cmd == CMD_LOOKUP) begin
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (row_live[i] && row_age[i] < row_age[hit]) row_age[i]++;
        end
        row_age[hit] = 0;
        r.found_hi = row_val_hi[hit];
        r.found_lo = row_val_lo[hit];
      end
    end else if (cmd == CMD_UPDATE) begin
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        row_val_hi[hit] = vh;
        row_val_lo[hit] = vl;
      end
    end else if (hit >= 0) begin
      r.status = ST_EXISTS;
    end else begin
      if (live_rows >= capacity() && live_rows > 0) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (row_live[i] && (victim < 0 || row_age[i] > row_age[victim])) victim = i;
        end
        row_live[victim] = 1'b0;
        live_rows--;
        r.evicted = 1'b1;
        r.victim_hi = row_key_hi[victim];
        r.victim_lo = row_key_lo[victim];
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (free_row < 0 && !row_live[i]) free_row = i;
      end
      if (free_row >= 0) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (row_live[i]) row_age[i]++;
        end
        row_live[free_row] = 1'b1;
        row_age[free_row] = 0;
        row_key_hi[free_row] = kh;
        row_key_lo[free_row] = kl;
        row_val_hi[free_row] = vh;
        row_val_lo[free_row] = vl;
        live_rows++;
      end
    end
    awaited_replies.push_back(r);
  endfunction

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h actual %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_replies.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_count++;
      end else begin
        head_reply = awaited_replies.pop_front();
        replies_checked++;
        if (head_reply.status == ST_OK && head_reply.found_hi != '0) hit_count++;
        if (head_reply.status == ST_NOT_FOUND) miss_count++;
        if (head_reply.status == ST_EXISTS) dup_count++;
        if (head_reply.evicted) evict_count++;
        check_field("status", WORD_W'(head_reply.status), WORD_W'(status_o));
        check_field("found_value_high", head_reply.found_hi, found_value_high_o);
        check_field("found_value_low", head_reply.found_lo, found_value_low_o);
        check_field("evicted", WORD_W'(head_reply.evicted), WORD_W'(evicted_o));
        check_field("evicted_key_high", head_reply.victim_hi, evicted_key_high_o);
        check_field("evicted_key_low", head_reply.victim_lo, evicted_key_low_o);
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i = 1'b0;
        rx_hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        stall_left = $urandom_range(0, 16);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic push_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] kh,
                              logic [WORD_W-1:0] kl, logic [WORD_W-1:0] vh,
                              logic [WORD_W-1:0] vl);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    command_i = cmd;
    key_high_i = kh;
    key_low_i = kl;
    value_high_i = vh;
    value_low_i = vl;
    do @(posedge clk_i); while (!in_ready_o);
    table_apply(cmd, kh, kl, vh, vl);
    items_sent++;
  endtask

  task automatic settle_table();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [PDATA_W-1:0] data);
    settle_table();
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REG_ENTRY_LIMIT;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    limit_reg = data[LIMIT_W-1:0];
    limit_writes++;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(limit_reg)) begin
      $error("entry_limit readback mismatch: expected %h actual %h",
             PDATA_W'(limit_reg), prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic refill_key_pool();
    pool_n = capacity() + $urandom_range(1, 8);
    for (int i = 0; i < pool_n; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
      // keys that agree in one half only
      if (i > 0 && $urandom_range(0, 3) == 0) pool_hi[i] = pool_hi[i-1];
      else if (i > 0 && $urandom_range(0, 3) == 0) pool_lo[i] = pool_lo[i-1];
    end
  endtask

  task automatic random_command();
    int pick;
    int sel;
    logic [CMD_W-1:0] cmd;
    logic [WORD_W-1:0] kh;
    logic [WORD_W-1:0] kl;
    pick = $urandom_range(0, 99);
    if (pick < 38) cmd = CMD_LOOKUP;
    else if (pick < 68) cmd = CMD_ADD;
    else if (pick < 90) cmd = CMD_UPDATE;
    else if (pick < 95) cmd = CMD_NOP;
    else cmd = CMD_W'($urandom_range(0, 3));
    if (pick >= 95 || $urandom_range(0, 9) == 0) begin
      kh = {$urandom, $urandom};
      kl = {$urandom, $urandom};
    end else begin
      sel = $urandom_range(0, pool_n - 1);
      kh = pool_hi[sel];
      kl = pool_lo[sel];
    end
    push_command(cmd, kh, kl, {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic test_table_basics();
    logic [WORD_W-1:0] ones;
    ones = '1;
    push_command(CMD_LOOKUP, '0, '0, '0, '0);
    push_command(CMD_UPDATE, ones, ones, ones, ones);
    push_command(CMD_ADD, '0, '0, ones, ones);
    push_command(CMD_ADD, ones, ones, '0, '0);
    push_command(CMD_ADD, '0, '0, {$urandom, $urandom}, {$urandom, $urandom});
    push_command(CMD_LOOKUP, '0, '0, '0, '0);
    push_command(CMD_ADD, ones, '0, {$urandom, $urandom}, {$urandom, $urandom});
    push_command(CMD_LOOKUP, '0, ones, '0, '0);
    push_command(CMD_UPDATE, ones, ones, {$urandom, $urandom}, {$urandom, $urandom});
    push_command(CMD_LOOKUP, ones, ones, '0, '0);
    push_command(CMD_NOP, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
    push_command(CMD_NOP, ones, ones, ones, ones);
  endtask

  task automatic test_lru_order();
    logic [WORD_W-1:0] ka;
    logic [WORD_W-1:0] kb;
    ka = {$urandom, $urandom};
    kb = {$urandom, $urandom};
    write_limit(2);
    push_command(CMD_ADD, ka, kb, {$urandom, $urandom}, {$urandom, $urandom});
    push_command(CMD_ADD, kb, ka, {$urandom, $urandom}, {$urandom, $urandom});
    push_command(CMD_LOOKUP, ka, kb, '0, '0);
    push_command(CMD_ADD, ka, ka, {$urandom, $urandom}, {$urandom, $urandom});
    push_command(CMD_UPDATE, ka, kb, {$urandom, $urandom}, {$urandom, $urandom});
    push_command(CMD_ADD, kb, kb, {$urandom, $urandom}, {$urandom, $urandom});
    push_command(CMD_LOOKUP, kb, ka, '0, '0);
  endtask

  task automatic test_limit_floor();
    logic [WORD_W-1:0] ke;
    ke = {$urandom, $urandom};
    write_limit(0);
    push_command(CMD_ADD, ke, '0, {$urandom, $urandom}, {$urandom, $urandom});
    push_command(CMD_ADD, '0, ke, {$urandom, $urandom}, {$urandom, $urandom});
    push_command(CMD_LOOKUP, ke, '0, '0, '0);
  endtask

  task automatic test_backpressure();
    write_limit(16);
    refill_key_pool();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_command();
    rx_hold_left = 400;
    repeat (40) random_command();
  endtask

  task automatic test_random_phases();
    logic [PDATA_W-1:0] settings [8];
    settings = '{32'd31, 32'd3, 32'd16, 32'd1, 32'hFFFF_FFE9, 32'd17, 32'd0, 32'd12};
    for (int p = 0; p < 8; p++) begin
      write_limit(settings[p]);
      refill_key_pool();
      tx_idle_en = (p != 7) && (p != 2);
      rx_idle_en = (p != 7) && (p != 4);
      repeat (205) random_command();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = '0;
    key_high_i = '0;
    key_low_i = '0;
    value_high_i = '0;
    value_low_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rx_hold_left = 0;
    fail_count = 0;
    items_sent = 0;
    replies_checked = 0;
    hit_count = 0;
    evict_count = 0;
    miss_count = 0;
    dup_count = 0;
    limit_writes = 0;
    limit_reg = LIMIT_RESET;
    live_rows = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      row_live[i] = 1'b0;
      row_age[i] = 0;
      row_key_hi[i] = '0;
      row_key_lo[i] = '0;
      row_val_hi[i] = '0;
      row_val_lo[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_table_basics();
    test_lru_order();
    test_limit_floor();
    test_backpressure();
    test_random_phases();

    settle_table();
    $display("Sent %0d commands, checked %0d results across %0d entry_limit writes",
             items_sent, replies_checked, limit_writes);
    $display("Lookup hits %0d, evictions %0d, not found %0d, duplicate adds %0d",
             hit_count, evict_count, miss_count, dup_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #7200000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
design/lkv_pkg.sv
design/lkv_store.sv
design/lkv_rank.sv
design/lru_key_value_table_top.sv
bench/lru_key_value_table_top_tb.sv
